// File: rtl/stcf_pkg.sv
package stcf_pkg;

  localparam int unsigned VecW     = 16;
  localparam int unsigned PosW     = 21;
  localparam int unsigned OrgW     = 14;
  localparam int unsigned SizeW    = 13;
  localparam int unsigned MagW     = 17;
  localparam int unsigned DvsW     = 18;
  localparam int unsigned QuoW     = 21;
  localparam int unsigned NumW     = 37;
  localparam int unsigned PosFrac  = 8;
  localparam int unsigned MaxFace  = 4096;
  localparam int unsigned SizeRst  = 1024;
  localparam int unsigned PosOff   = 128;

  localparam logic [2:0] FacePosX = 3'd0;
  localparam logic [2:0] FaceNegX = 3'd1;
  localparam logic [2:0] FacePosY = 3'd2;
  localparam logic [2:0] FaceNegY = 3'd3;
  localparam logic [2:0] FacePosZ = 3'd4;
  localparam logic [2:0] FaceNegZ = 3'd5;

  typedef struct packed {
    logic [2:0]      face;
    logic [OrgW-1:0] ocol;
    logic [OrgW-1:0] orow;
    logic            zero;
  } side_t;

  typedef struct packed {
    logic [MagW-1:0] rem;
    logic [QuoW-1:0] num;
    logic [QuoW-1:0] quo;
  } lane_t;

  typedef struct packed {
    side_t           side;
    logic [DvsW-1:0] dvs;
    lane_t           col;
    lane_t           row;
  } divw_t;

endpackage

// File: rtl/stcf_prep.sv
module stcf_prep (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en0_i,
  input  logic                             en1_i,
  input  logic                             valid_i,
  input  logic signed [stcf_pkg::VecW-1:0] x_i,
  input  logic signed [stcf_pkg::VecW-1:0] y_i,
  input  logic signed [stcf_pkg::VecW-1:0] z_i,
  input  logic [stcf_pkg::SizeW-1:0]       size_i,
  output logic                             valid0_o,
  output logic                             valid1_o,
  output stcf_pkg::divw_t                  data_o
);

  localparam int unsigned MW = stcf_pkg::MagW;
  localparam int unsigned SW = stcf_pkg::SizeW;

  logic signed [MW-1:0] sx, sy, sz, cu, cv;
  logic [MW-1:0] ax, ay, az, dm;
  logic signed [MW:0] su, sv;
  logic xsel, ysel, zero;
  logic [SW-1:0] a;
  stcf_pkg::side_t side;

  logic [MW-1:0] scol_q, srow_q, d_q;
  logic [SW-1:0] a_q;
  stcf_pkg::side_t side_q;
  logic v0_q, v1_q;
  stcf_pkg::divw_t data_q;

  logic [29:0] pc, pr;
  logic [stcf_pkg::NumW-1:0] nc, nr;

  always_comb begin
    sx = MW'(x_i);
    sy = MW'(y_i);
    sz = MW'(z_i);
    ax = sx[MW-1] ? MW'(-sx) : MW'(sx);
    ay = sy[MW-1] ? MW'(-sy) : MW'(sy);
    az = sz[MW-1] ? MW'(-sz) : MW'(sz);
    zero = (ax == '0) && (ay == '0) && (az == '0);
    xsel = (ax >= ay) && (ax >= az);
    ysel = !xsel && (ay >= az);
    if (size_i == '0) begin
      a = SW'(1);
    end else if (size_i > SW'(stcf_pkg::MaxFace)) begin
      a = SW'(stcf_pkg::MaxFace);
    end else begin
      a = size_i;
    end
    side.zero = zero;
    if (xsel) begin
      dm = ax;
      if (x_i > 0) begin
        side.face = stcf_pkg::FacePosX; cu = -sz; cv = -sy;
        side.ocol = stcf_pkg::OrgW'({a, 1'b0}); side.orow = stcf_pkg::OrgW'(a);
      end else begin
        side.face = stcf_pkg::FaceNegX; cu = sz; cv = -sy;
        side.ocol = '0; side.orow = stcf_pkg::OrgW'(a);
      end
    end else if (ysel) begin
      dm = ay;
      if (y_i > 0) begin
        side.face = stcf_pkg::FacePosY; cu = sx; cv = sz;
        side.ocol = stcf_pkg::OrgW'(a); side.orow = '0;
      end else begin
        side.face = stcf_pkg::FaceNegY; cu = sx; cv = -sz;
        side.ocol = stcf_pkg::OrgW'(a); side.orow = stcf_pkg::OrgW'({a, 1'b0});
      end
    end else begin
      dm = az;
      if (z_i > 0) begin
        side.face = stcf_pkg::FacePosZ; cu = sx; cv = -sy;
        side.ocol = stcf_pkg::OrgW'(a); side.orow = stcf_pkg::OrgW'(a);
      end else begin
        side.face = stcf_pkg::FaceNegZ; cu = -sx; cv = -sy;
        side.ocol = stcf_pkg::OrgW'(3 * a); side.orow = stcf_pkg::OrgW'(a);
      end
    end
    if (zero) begin
      dm = MW'(1);
    end
    su = (MW + 1)'(cu) + (MW + 1)'(dm);
    sv = (MW + 1)'(cv) + (MW + 1)'(dm);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      if (en0_i) v0_q <= valid_i;
      if (en1_i) v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en0_i) begin
      scol_q <= su[MW-1:0];
      srow_q <= sv[MW-1:0];
      d_q    <= dm;
      a_q    <= a;
      side_q <= side;
    end
  end

  // scaled numerator plus half the divisor, so the quotient rounds to nearest
  always_comb begin
    pc = 30'(scol_q) * 30'(a_q);
    pr = 30'(srow_q) * 30'(a_q);
    nc = stcf_pkg::NumW'({pc, {stcf_pkg::PosFrac{1'b0}}}) + stcf_pkg::NumW'(d_q);
    nr = stcf_pkg::NumW'({pr, {stcf_pkg::PosFrac{1'b0}}}) + stcf_pkg::NumW'(d_q);
  end

  always_ff @(posedge clk_i) begin
    if (en1_i) begin
      data_q.side    <= side_q;
      data_q.dvs     <= {d_q, 1'b0};
      data_q.col.rem <= MW'(nc[stcf_pkg::NumW-1:stcf_pkg::QuoW]);
      data_q.col.num <= nc[stcf_pkg::QuoW-1:0];
      data_q.col.quo <= '0;
      data_q.row.rem <= MW'(nr[stcf_pkg::NumW-1:stcf_pkg::QuoW]);
      data_q.row.num <= nr[stcf_pkg::QuoW-1:0];
      data_q.row.quo <= '0;
    end
  end

  assign valid0_o = v0_q;
  assign valid1_o = v1_q;
  assign data_o   = data_q;

endmodule

// File: rtl/stcf_div_cell.sv
module stcf_div_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  stcf_pkg::divw_t data_i,
  output logic            valid_o,
  output stcf_pkg::divw_t data_o
);

  logic valid_q;
  stcf_pkg::divw_t data_q, data_d;
  logic [stcf_pkg::DvsW-1:0] tc, tr, rc, rr;
  logic gc, gr;

  always_comb begin
    tc = {data_i.col.rem, data_i.col.num[stcf_pkg::QuoW-1]};
    tr = {data_i.row.rem, data_i.row.num[stcf_pkg::QuoW-1]};
    gc = tc >= data_i.dvs;
    gr = tr >= data_i.dvs;
    rc = gc ? tc - data_i.dvs : tc;
    rr = gr ? tr - data_i.dvs : tr;
    data_d = data_i;
    data_d.col.rem = rc[stcf_pkg::MagW-1:0];
    data_d.row.rem = rr[stcf_pkg::MagW-1:0];
    data_d.col.num = {data_i.col.num[stcf_pkg::QuoW-2:0], 1'b0};
    data_d.row.num = {data_i.row.num[stcf_pkg::QuoW-2:0], 1'b0};
    data_d.col.quo = {data_i.col.quo[stcf_pkg::QuoW-2:0], gc};
    data_d.row.quo = {data_i.row.quo[stcf_pkg::QuoW-2:0], gr};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// File: rtl/sphere_to_cubemap_face_coords_top.sv
// Cube-map face selection for a 4x3 frame.
// Input stream: s_axis_tdata carries one direction vector (three signed Q1.14
// components). Output stream: m_axis_tdata carries the face index, the
// position inside the face (8 fraction bits, rounded to nearest) and the
// face origin in the frame, plus a zero-vector flag.
// face_size is written through cfg_we_i / cfg_wdata_i while the block is idle;
// reset sets it to 1024. Zero selects 1, values above 4096 saturate.
// The pipeline has 24 register stages: a select stage, a multiply stage, 21
// restoring-division cells (one quotient bit per cell, both coordinates side
// by side) and an output register. It takes one item per cycle while the
// output is not stalled. Each stage moves on when it is empty or the next
// stage moves, so bubbles close up while the output waits.
// When the receiver stalls, the full pipe holds and s_axis_tready falls.
// Reset empties the pipeline; no output transfer is pending afterwards.
module sphere_to_cubemap_face_coords_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [12:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // vec_x, vec_y, vec_z
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata   // face_index, pos_col, pos_row, origin_col,
                                     // origin_row, zero_vector, zero pad
);

  localparam int unsigned NCell = stcf_pkg::QuoW;

  logic [stcf_pkg::SizeW-1:0] size_q;
  logic [NCell:0] cv;
  stcf_pkg::divw_t cd [NCell+1];
  logic [NCell+1:0] en;
  logic v0;
  logic vo_q;
  logic [79:0] do_q;
  logic [stcf_pkg::QuoW-1:0] qc, qr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= stcf_pkg::SizeW'(stcf_pkg::SizeRst);
    end else if (cfg_we_i) begin
      size_q <= cfg_wdata_i;
    end
  end

  // stage enables, last stage first
  always_comb begin
    en[NCell+1] = !vo_q || m_axis_tready;
    for (int k = NCell; k >= 0; k--) begin
      en[k] = !cv[k] || en[k+1];
    end
  end

  stcf_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en0_i   (!v0 || en[0]),
    .en1_i   (en[0]),
    .valid_i (s_axis_tvalid),
    .x_i     (s_axis_tdata[15:0]),
    .y_i     (s_axis_tdata[31:16]),
    .z_i     (s_axis_tdata[47:32]),
    .size_i  (size_q),
    .valid0_o(v0),
    .valid1_o(cv[0]),
    .data_o  (cd[0])
  );

  assign s_axis_tready = !v0 || en[0];

  for (genvar i = 0; i < NCell; i++) begin : g_cell
    stcf_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en[i+1]),
      .valid_i(cv[i]),
      .data_i (cd[i]),
      .valid_o(cv[i+1]),
      .data_o (cd[i+1])
    );
  end

  always_comb begin
    qc = cd[NCell].col.quo - stcf_pkg::QuoW'(stcf_pkg::PosOff);
    qr = cd[NCell].row.quo - stcf_pkg::QuoW'(stcf_pkg::PosOff);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (en[NCell+1]) begin
      vo_q <= cv[NCell];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NCell+1]) begin
      if (cd[NCell].side.zero) begin
        do_q <= 80'(1) << 73;
      end else begin
        do_q <= {6'b0, 1'b0, cd[NCell].side.orow, cd[NCell].side.ocol,
                 qr, qc, cd[NCell].side.face};
      end
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = do_q;

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic                      zero;
    logic [stcf_pkg::OrgW-1:0] orow;
    logic [stcf_pkg::OrgW-1:0] ocol;
    logic [stcf_pkg::PosW-1:0] prow;
    logic [stcf_pkg::PosW-1:0] pcol;
    logic [2:0]                face;
  } face_res_t;

  typedef struct {
    logic [15:0] x, y, z;
    bit          typed;
    face_res_t   res;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [12:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;

  face_res_t   face_q[$];
  int unsigned face_size_cur = stcf_pkg::SizeRst;
  int          mismatches = 0;
  int          cycles = 0;
  bit          calm = 1'b0;
  int          stall_left = 0;

  sphere_to_cubemap_face_coords_top i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint face_pos(longint c, longint d, longint a);
    longint num, den;
    num = ((c + d) * a - d) * (longint'(1) << stcf_pkg::PosFrac) + d;
    den = 2 * d;
    if (num >= 0) return num / den;
    return -((-num + den - 1) / den);
  endfunction

  function automatic face_res_t predict_face(logic [15:0] xr, logic [15:0] yr,
                                             logic [15:0] zr, int unsigned fs);
    face_res_t r;
    longint x, y, z, ax, ay, az, a, d, cu, cv;
    x = longint'($signed(xr));
    y = longint'($signed(yr));
    z = longint'($signed(zr));
    ax = x < 0 ? -x : x;
    ay = y < 0 ? -y : y;
    az = z < 0 ? -z : z;
    a = fs;
    if (a < 1) a = 1;
    if (a > stcf_pkg::MaxFace) a = stcf_pkg::MaxFace;
    r = '0;
    if (ax == 0 && ay == 0 && az == 0) begin
      r.zero = 1'b1;
      return r;
    end
    if (ax >= ay && ax >= az) begin
      d = ax;
      cv = -y;
      r.orow = stcf_pkg::OrgW'(a);
      if (x > 0) begin
        r.face = stcf_pkg::FacePosX; cu = -z; r.ocol = stcf_pkg::OrgW'(2 * a);
      end else begin
        r.face = stcf_pkg::FaceNegX; cu = z; r.ocol = '0;
      end
    end else if (ay >= az) begin
      d = ay;
      cu = x;
      r.ocol = stcf_pkg::OrgW'(a);
      if (y > 0) begin
        r.face = stcf_pkg::FacePosY; cv = z; r.orow = '0;
      end else begin
        r.face = stcf_pkg::FaceNegY; cv = -z; r.orow = stcf_pkg::OrgW'(2 * a);
      end
    end else begin
      d = az;
      cv = -y;
      r.orow = stcf_pkg::OrgW'(a);
      if (z > 0) begin
        r.face = stcf_pkg::FacePosZ; cu = x; r.ocol = stcf_pkg::OrgW'(a);
      end else begin
        r.face = stcf_pkg::FaceNegZ; cu = -x; r.ocol = stcf_pkg::OrgW'(3 * a);
      end
    end
    r.pcol = stcf_pkg::PosW'(face_pos(cu, d, a));
    r.prow = stcf_pkg::PosW'(face_pos(cv, d, a));
    return r;
  endfunction

  function automatic logic [15:0] rand_within(int d);
    return 16'(int'($urandom_range(2 * d)) - d);
  endfunction

  task automatic send_vec(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                          bit typed, face_res_t res);
    int gap;
    if (!calm && $urandom_range(3) == 0) begin
      s_axis_tvalid <= 1'b0;
      gap = $urandom_range(1, 8);
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {z, y, x};
    do @(posedge clk_i); while (!s_axis_tready);
    face_q = {face_q, (typed ? res : predict_face(x, y, z, face_size_cur))};
    @(negedge clk_i);
  endtask

  task automatic send_random;
    int d, pick, mode;
    logic [15:0] v[3];
    mode = $urandom_range(7);
    if (mode == 0) begin
      foreach (v[i]) v[i] = 16'($urandom);
    end else begin
      case ($urandom_range(4))
        0: d = 16384;
        1: d = 32768;
        2: d = $urandom_range(1, 4);
        default: d = $urandom_range(1, 16384);
      endcase
      foreach (v[i]) v[i] = (mode == 1) ? 16'($urandom_range(1) ? d : -d) : rand_within(d);
      pick = $urandom_range(2);
      v[pick] = $urandom_range(1) ? 16'(d) : 16'(-d);
      if (mode == 2) v[(pick + 1) % 3] = 16'd0;
      if (mode == 3 && $urandom_range(3) == 0) v = '{16'd0, 16'd0, 16'd0};
    end
    send_vec(v[0], v[1], v[2], 1'b0, '0);
  endtask

  task automatic write_size(logic [12:0] val);
    s_axis_tvalid <= 1'b0;
    while (face_q.size() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    face_size_cur = val;
  endtask

  // receiver side stalls
  always @(negedge clk_i) begin
    if (calm) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(4) == 0) begin
      stall_left = $urandom_range(0, 7);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    face_res_t got, want;
    cycles++;
    if (cycles > 400000) begin
      $display("sphere_to_cubemap_face_coords_top test failed");
      $finish;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[73:0];
      if (face_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected transfer %h", got);
      end else begin
        want = face_q.pop_front();
        if (got.face !== want.face || got.pcol !== want.pcol || got.prow !== want.prow ||
            got.ocol !== want.ocol || got.orow !== want.orow || got.zero !== want.zero) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp f%0d c%h r%h oc%0d or%0d z%b got f%0d c%h r%h oc%0d or%0d z%b",
                     want.face, want.pcol, want.prow, want.ocol, want.orow, want.zero,
                     got.face, got.pcol, got.prow, got.ocol, got.orow, got.zero);
        end
      end
    end
  end

  dir_row_t dir_tab[20];
  logic [12:0] sizes[7] = '{13'd1, 13'd4096, 13'd0, 13'd8191, 13'd3, 13'd1024, 13'd1};

  initial begin
    dir_tab = '{
      '{16'd0, 16'd0, 16'd0, 1'b1, {1'b1, 14'd0, 14'd0, 21'd0, 21'd0, 3'd0}},
      '{16'd16384, 16'd0, 16'd0, 1'b1,
        {1'b0, 14'd1024, 14'd2048, 21'd130944, 21'd130944, stcf_pkg::FacePosX}},
      '{-16'sd16384, 16'd0, 16'd0, 1'b0, '0},
      '{16'd0, 16'd16384, 16'd0, 1'b0, '0},
      '{16'd0, -16'sd16384, 16'd0, 1'b0, '0},
      '{16'd0, 16'd0, 16'd16384, 1'b0, '0},
      '{16'd0, 16'd0, -16'sd16384, 1'b0, '0},
      '{16'd8000, 16'd8000, 16'd8000, 1'b0, '0},
      '{-16'sd8000, 16'd8000, 16'd0, 1'b0, '0},
      '{16'd0, -16'sd5, 16'd5, 1'b0, '0},
      '{16'h8000, 16'd100, 16'h8000, 1'b0, '0},
      '{16'd32767, 16'h8000, 16'd0, 1'b0, '0},
      '{16'd16384, 16'd16384, -16'sd16384, 1'b0, '0},
      '{16'd16384, -16'sd16384, 16'd16384, 1'b0, '0},
      '{16'd1, 16'd0, 16'd0, 1'b0, '0},
      '{16'd0, 16'd0, -16'sd1, 1'b0, '0},
      '{-16'sd1, 16'd1, -16'sd1, 1'b0, '0},
      '{16'd12345, -16'sd6789, 16'd16000, 1'b0, '0},
      '{16'h8000, 16'h8000, 16'h8000, 1'b0, '0},
      '{16'hffff, 16'h7fff, 16'h8001, 1'b0, '0}
    };
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    foreach (dir_tab[i])
      send_vec(dir_tab[i].x, dir_tab[i].y, dir_tab[i].z, dir_tab[i].typed, dir_tab[i].res);
    repeat (150) send_random();
    foreach (sizes[p]) begin
      write_size(sizes[p] == 13'd3 ? 13'($urandom_range(1, 8191)) : sizes[p]);
      if (p == 6) calm = 1'b1;
      repeat (130) send_random();
    end
    s_axis_tvalid <= 1'b0;
    while (face_q.size() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("sphere_to_cubemap_face_coords_top test passed");
    end else begin
      $display("sphere_to_cubemap_face_coords_top test failed");
    end
    $finish;
  end

endmodule
